[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and disabled
// while the synchronous reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/gridocc_pkg.sv]
// ----------------------------------------------------------------------------
// Grid occupancy package
// Types and codes shared by the grid occupancy store and its sub-modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gridocc_pkg;

  localparam int COORD_W = 9;

  typedef logic [COORD_W-1:0] coord_t;

  typedef enum logic [2:0] {
    ACT_READ      = 3'd0,
    ACT_WRITE     = 3'd1,
    ACT_FILL      = 3'd2,
    ACT_FIND_ROW  = 3'd3,
    ACT_FIND_COL  = 3'd4,
    ACT_CLEAR     = 3'd5
  } action_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_RANGE     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  localparam logic CFG_ROWS = 1'b0;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_CELL,
    S_RDWAIT,
    S_FILL,
    S_FIND,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctrl_t;

endpackage

[sv/gridocc_mem.sv]
// ----------------------------------------------------------------------------
// Grid cell memory
// Single-port byte memory holding the grid cells, with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gridocc_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic                   clk,
  input  gridocc_pkg::mem_ctrl_t ctrl,
  input  logic [AW-1:0]          addr,
  input  logic [7:0]             wr_data,
  output logic [7:0]             rd_data
);

  logic [7:0] cells_q [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (ctrl.we) begin
      cells_q[addr] <= wr_data;
    end
    if (ctrl.re) begin
      rd_data_r <= cells_q[addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[sv/gridocc_addr.sv]
// ----------------------------------------------------------------------------
// Grid address unit
// Shared multiply-add that maps a row and column to a row-major cell address.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gridocc_addr #(
  parameter int AW = 12
) (
  input  gridocc_pkg::coord_t row,
  input  gridocc_pkg::coord_t col,
  input  gridocc_pkg::coord_t cols,
  output logic [AW-1:0]       addr
);

  localparam int PW = 2 * gridocc_pkg::COORD_W;

  logic [PW-1:0] prod;
  logic [PW-1:0] sum;

  assign prod = PW'(row) * PW'(cols);
  assign sum  = prod + PW'(col);
  assign addr = sum[AW-1:0];

endmodule

[sv/grid_occupancy_fill_and_search.sv]
// ----------------------------------------------------------------------------
// Grid occupancy store with fill and search
// Byte grid recording which table cells are taken, with cell access,
// rectangle fill, row and column search and clear, run by a small sequencer.
// ----------------------------------------------------------------------------
// One transaction is handled at a time; in_ready is high only while idle.
// A cell read passes through a cell state, which issues the memory read,
// and a read-wait state that registers the data; a write needs only the
// cell state. A fill writes its rectangle cell by cell, row by row, with a
// range status where it runs off the grid; a clear zeroes the grid in use
// the same way. A search reads its row or column in turn until a byte
// matches, and goes straight to the result when it lies outside the grid.
// The single memory port takes one access a cycle through the shared
// address multiply-add. After reset a clearing pass writes zero to all
// MAX_ROWS * MAX_COLUMNS entries before the first input transaction is
// taken; configuration writes are taken always.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module grid_occupancy_fill_and_search #(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLUMNS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_action,
  input  logic [7:0] in_row_pos,
  input  logic [7:0] in_col_pos,
  input  logic [6:0] in_row_span,
  input  logic [6:0] in_col_span,
  input  logic [7:0] in_cell_value,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_status,
  output logic [5:0] out_found_index,
  output logic [7:0] out_read_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [6:0] cfg_data
);

  localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam gridocc_pkg::coord_t MAX_R = gridocc_pkg::coord_t'(MAX_ROWS);
  localparam gridocc_pkg::coord_t MAX_C = gridocc_pkg::coord_t'(MAX_COLUMNS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  gridocc_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]       init_cnt_r, init_cnt_nxt;
  logic [6:0]          rows_r, rows_nxt;
  logic [6:0]          cols_r, cols_nxt;
  logic [2:0]          act_r, act_nxt;
  gridocc_pkg::coord_t r_r, r_nxt;
  gridocc_pkg::coord_t c_r, c_nxt;
  gridocc_pkg::coord_t c_start_r, c_start_nxt;
  gridocc_pkg::coord_t r_end_r, r_end_nxt;
  gridocc_pkg::coord_t c_end_r, c_end_nxt;
  logic [7:0]          val_r, val_nxt;
  logic                pend_r, pend_nxt;
  logic [5:0]          pos_d_r, pos_d_nxt;
  logic [1:0]          res_status_r, res_status_nxt;
  logic [5:0]          res_found_r, res_found_nxt;
  logic [7:0]          res_data_r, res_data_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [1:0]          out_status_r, out_status_nxt;
  logic [5:0]          out_found_r, out_found_nxt;
  logic [7:0]          out_data_r, out_data_nxt;

  gridocc_pkg::coord_t    eff_r, eff_c, rows_ext, cols_ext;
  gridocc_pkg::coord_t    find_pos, find_lim;
  gridocc_pkg::mem_ctrl_t mem_ctrl;
  logic [AW-1:0]          agu_addr, mem_addr;
  logic [7:0]             mem_wdata, mem_rdata;
  logic                   in_fire, cfg_fire, out_free;
  logic                   span_zero, clear_zero, row_oob, col_oob;
  logic                   cell_in, fill_last_c, fill_last;
  logic                   find_row, issue, match, find_end;

  assign rows_ext = gridocc_pkg::coord_t'(rows_r);
  assign cols_ext = gridocc_pkg::coord_t'(cols_r);
  assign eff_r    = (rows_ext > MAX_R) ? MAX_R : rows_ext;
  assign eff_c    = (cols_ext > MAX_C) ? MAX_C : cols_ext;

  assign in_ready  = (state_r == gridocc_pkg::S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign out_free  = !out_valid_r || out_ready;

  assign span_zero  = (in_row_span == 7'd0) || (in_col_span == 7'd0);
  assign clear_zero = (eff_r == '0) || (eff_c == '0);
  assign row_oob    = gridocc_pkg::coord_t'(in_row_pos) >= eff_r;
  assign col_oob    = gridocc_pkg::coord_t'(in_col_pos) >= eff_c;

  assign cell_in     = (r_r < eff_r) && (c_r < eff_c);
  assign fill_last_c = (c_r + 1'b1) == c_end_r;
  assign fill_last   = fill_last_c && ((r_r + 1'b1) == r_end_r);

  assign find_row = (act_r == gridocc_pkg::ACT_FIND_ROW);
  assign find_pos = find_row ? c_r : r_r;
  assign find_lim = find_row ? eff_c : eff_r;
  assign issue    = find_pos < find_lim;
  assign match    = pend_r && (mem_rdata == val_r);
  assign find_end = match || !issue;

  gridocc_addr #(
    .AW (AW)
  ) u_addr (
    .row  (r_r),
    .col  (c_r),
    .cols (eff_c),
    .addr (agu_addr)
  );

  assign mem_addr  = (state_r == gridocc_pkg::S_INIT) ? init_cnt_r : agu_addr;
  assign mem_wdata = (state_r == gridocc_pkg::S_INIT) ? 8'd0 : val_r;

  gridocc_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .ctrl    (mem_ctrl),
    .addr    (mem_addr),
    .wr_data (mem_wdata),
    .rd_data (mem_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gridocc_pkg::S_INIT: begin
        if (init_cnt_r == LAST_ADDR) begin
          state_nxt = gridocc_pkg::S_IDLE;
        end
      end
      gridocc_pkg::S_IDLE: begin
        if (in_fire) begin
          case (in_action)
            gridocc_pkg::ACT_READ,
            gridocc_pkg::ACT_WRITE: state_nxt = gridocc_pkg::S_CELL;
            gridocc_pkg::ACT_FILL: begin
              state_nxt = span_zero ? gridocc_pkg::S_RESULT : gridocc_pkg::S_FILL;
            end
            gridocc_pkg::ACT_CLEAR: begin
              state_nxt = clear_zero ? gridocc_pkg::S_RESULT : gridocc_pkg::S_FILL;
            end
            gridocc_pkg::ACT_FIND_ROW: begin
              state_nxt = row_oob ? gridocc_pkg::S_RESULT : gridocc_pkg::S_FIND;
            end
            gridocc_pkg::ACT_FIND_COL: begin
              state_nxt = col_oob ? gridocc_pkg::S_RESULT : gridocc_pkg::S_FIND;
            end
            default: state_nxt = gridocc_pkg::S_RESULT;
          endcase
        end
      end
      gridocc_pkg::S_CELL: begin
        if (act_r == gridocc_pkg::ACT_READ && cell_in) begin
          state_nxt = gridocc_pkg::S_RDWAIT;
        end else begin
          state_nxt = gridocc_pkg::S_RESULT;
        end
      end
      gridocc_pkg::S_RDWAIT: state_nxt = gridocc_pkg::S_RESULT;
      gridocc_pkg::S_FILL: begin
        if (!cell_in || fill_last) begin
          state_nxt = gridocc_pkg::S_RESULT;
        end
      end
      gridocc_pkg::S_FIND: begin
        if (find_end) begin
          state_nxt = gridocc_pkg::S_RESULT;
        end
      end
      gridocc_pkg::S_RESULT: begin
        if (out_free) begin
          state_nxt = gridocc_pkg::S_IDLE;
        end
      end
      default: state_nxt = gridocc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    init_cnt_nxt   = init_cnt_r;
    rows_nxt       = rows_r;
    cols_nxt       = cols_r;
    act_nxt        = act_r;
    r_nxt          = r_r;
    c_nxt          = c_r;
    c_start_nxt    = c_start_r;
    r_end_nxt      = r_end_r;
    c_end_nxt      = c_end_r;
    val_nxt        = val_r;
    pend_nxt       = 1'b0;
    pos_d_nxt      = pos_d_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    res_data_nxt   = res_data_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_data_nxt   = out_data_r;
    mem_ctrl       = '0;

    if (cfg_fire) begin
      if (cfg_index == gridocc_pkg::CFG_ROWS) begin
        rows_nxt = cfg_data;
      end else begin
        cols_nxt = cfg_data;
      end
    end

    case (state_r)
      gridocc_pkg::S_INIT: begin
        mem_ctrl.we  = 1'b1;
        init_cnt_nxt = init_cnt_r + 1'b1;
      end
      gridocc_pkg::S_IDLE: begin
        if (in_fire) begin
          act_nxt        = in_action;
          r_nxt          = gridocc_pkg::coord_t'(in_row_pos);
          c_nxt          = gridocc_pkg::coord_t'(in_col_pos);
          c_start_nxt    = gridocc_pkg::coord_t'(in_col_pos);
          r_end_nxt      = gridocc_pkg::coord_t'(in_row_pos)
                         + gridocc_pkg::coord_t'(in_row_span);
          c_end_nxt      = gridocc_pkg::coord_t'(in_col_pos)
                         + gridocc_pkg::coord_t'(in_col_span);
          val_nxt        = in_cell_value;
          res_status_nxt = gridocc_pkg::ST_OK;
          res_found_nxt  = '0;
          res_data_nxt   = '0;
          case (in_action)
            gridocc_pkg::ACT_CLEAR: begin
              r_nxt       = '0;
              c_nxt       = '0;
              c_start_nxt = '0;
              r_end_nxt   = eff_r;
              c_end_nxt   = eff_c;
              val_nxt     = 8'd0;
            end
            gridocc_pkg::ACT_FIND_ROW: begin
              if (row_oob) begin
                res_status_nxt = gridocc_pkg::ST_NOT_FOUND;
              end
            end
            gridocc_pkg::ACT_FIND_COL: begin
              if (col_oob) begin
                res_status_nxt = gridocc_pkg::ST_NOT_FOUND;
              end
            end
            gridocc_pkg::ACT_READ,
            gridocc_pkg::ACT_WRITE,
            gridocc_pkg::ACT_FILL: ;
            default: res_status_nxt = gridocc_pkg::ST_RANGE;
          endcase
        end
      end
      gridocc_pkg::S_CELL: begin
        if (cell_in) begin
          mem_ctrl.re = (act_r == gridocc_pkg::ACT_READ);
          mem_ctrl.we = (act_r == gridocc_pkg::ACT_WRITE);
        end else begin
          res_status_nxt = gridocc_pkg::ST_RANGE;
        end
      end
      gridocc_pkg::S_RDWAIT: begin
        res_data_nxt = mem_rdata;
      end
      gridocc_pkg::S_FILL: begin
        if (cell_in) begin
          mem_ctrl.we = 1'b1;
          if (fill_last_c) begin
            c_nxt = c_start_r;
            r_nxt = r_r + 1'b1;
          end else begin
            c_nxt = c_r + 1'b1;
          end
        end else begin
          res_status_nxt = gridocc_pkg::ST_RANGE;
        end
      end
      gridocc_pkg::S_FIND: begin
        mem_ctrl.re = issue && !find_end;
        pend_nxt    = issue && !find_end;
        pos_d_nxt   = find_pos[5:0];
        if (issue) begin
          if (find_row) begin
            c_nxt = c_r + 1'b1;
          end else begin
            r_nxt = r_r + 1'b1;
          end
        end
        if (match) begin
          res_status_nxt = gridocc_pkg::ST_OK;
          res_found_nxt  = pos_d_r;
        end else if (find_end) begin
          res_status_nxt = gridocc_pkg::ST_NOT_FOUND;
        end
      end
      gridocc_pkg::S_RESULT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_found_nxt  = res_found_r;
          out_data_nxt   = res_data_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gridocc_pkg::S_INIT;
      init_cnt_r  <= '0;
      rows_r      <= '0;
      cols_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_cnt_r  <= init_cnt_nxt;
      rows_r      <= rows_nxt;
      cols_r      <= cols_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    r_r          <= r_nxt;
    c_r          <= c_nxt;
    c_start_r    <= c_start_nxt;
    r_end_r      <= r_end_nxt;
    c_end_r      <= c_end_nxt;
    val_r        <= val_nxt;
    pos_d_r      <= pos_d_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    res_data_r   <= res_data_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_index = out_found_r;
  assign out_read_data   = out_data_r;

  `ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, in_fire,
    state_r != gridocc_pkg::S_IDLE, "accepted transaction did not leave idle")
  `ASSERT_IMPLIES(a_rdwait_after_read, clk, rst_n, state_r == gridocc_pkg::S_RDWAIT,
    $past(mem_ctrl.re), "read data awaited without a memory read")
  `ASSERT_IMPLIES(a_pend_from_find, clk, rst_n, pend_r,
    $past(state_r == gridocc_pkg::S_FIND) && $past(mem_ctrl.re),
    "search compare pending without a search read")
  `ASSERT_NEXT(a_result_loaded, clk, rst_n, state_r == gridocc_pkg::S_RESULT && out_free,
    out_valid_r && state_r == gridocc_pkg::S_IDLE, "result not presented")

endmodule
